FILE: rtl/core/dq_pkg.sv
package dq_pkg;

   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;
   localparam int PORT_W   = 32;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_TAKE_FRONT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_TAKE_BACK  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // one command is broadcast to every cell of the chain
   typedef struct packed {
      logic shift_in_front;   // every cell takes its front neighbor's word
      logic shift_out_front;  // every cell takes its back neighbor's word
      logic load_back;        // the first unused cell loads the new word
      logic remove;           // cells at or behind the first match shift forward
   } cell_cmd_type;

endpackage

FILE: rtl/core/dq_cell.sv
module dq_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  dq_pkg::cell_cmd_type  cmd,
   input  logic [DATA_WIDTH-1:0] word,
   input  logic [CNT_W-1:0]      occ,
   input  logic [DATA_WIDTH-1:0] front_entry,
   input  logic [DATA_WIDTH-1:0] back_entry,
   input  logic                  hit_in,
   output logic                  hit_out,
   output logic                  is_last,
   output logic [DATA_WIDTH-1:0] entry
);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;
   logic                  live;
   logic                  match;

   assign live    = CNT_W'(INDEX) < occ;
   assign is_last = CNT_W'(INDEX + 1) == occ;
   assign match   = live && (entry_ff == word);
   // a hit anywhere in front of or at this cell
   assign hit_out = hit_in | match;
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.shift_in_front) begin
         entry_in = front_entry;
      end else if (cmd.shift_out_front) begin
         entry_in = back_entry;
      end else if (cmd.load_back && (CNT_W'(INDEX) == occ)) begin
         entry_in = word;
      end else if (cmd.remove && hit_out) begin
         entry_in = back_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: rtl/core/deque_with_remove_by_value.sv
// Bounded double-ended queue of words with remove by value.
// Request channel: req_valid/req_stall with req_action and req_value. The
// action is push front, push back, take front, take back or remove the
// first word from the front equal to req_value, closing the gap.
// Response channel: rsp_valid/rsp_stall; every request gives one response
// with the word taken (0 if none), a status, the new count and an empty flag.
// The response is registered at the edge that accepts the request.
// Throughput is one request per cycle while req_stall is low; every action,
// including the search and shift of a remove, completes at that edge, as the
// chain of storage cells compares and moves all entries at once.
// A push to a full queue is dropped with status full; a take from an empty
// queue gives status empty; a remove without a match gives status not found.
// The response register holds while rsp_stall is high; req_stall is raised
// only when a response waits and is stalled, so a request is taken in the
// same cycle that the pending response leaves.
// Reset empties the queue and clears rsp_valid; no clearing pass is needed.
module deque_with_remove_by_value #(
   parameter  int CAPACITY   = 16,
   parameter  int DATA_WIDTH = 32,
   localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dq_pkg::ACTION_W-1:0]   req_action,
   input  logic [dq_pkg::PORT_W-1:0]     req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dq_pkg::PORT_W-1:0]     rsp_taken_value,
   output logic [dq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [CNT_W-1:0]              rsp_count,
   output logic                          rsp_is_empty
);

   logic                          fire;
   logic [DATA_WIDTH-1:0]         word;
   dq_pkg::cell_cmd_type          cmd;
   logic [DATA_WIDTH-1:0]         entry_w [CAPACITY];
   logic [CAPACITY-1:0]           last_w;
   logic [CAPACITY:0]             hit_w;
   logic [DATA_WIDTH-1:0]         back_word;
   logic                          full;
   logic                          empty;

   logic [CNT_W-1:0]              occ_ff;
   logic [CNT_W-1:0]              occ_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [DATA_WIDTH-1:0]         taken_ff;
   logic [DATA_WIDTH-1:0]         taken_in;
   logic [dq_pkg::STATUS_W-1:0]   status_ff;
   logic [dq_pkg::STATUS_W-1:0]   status_in;
   logic [CNT_W-1:0]              count_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign fire      = req_valid & ~req_stall;

   generate
      if (DATA_WIDTH <= dq_pkg::PORT_W) begin : g_narrow
         assign word            = req_value[DATA_WIDTH-1:0];
         assign rsp_taken_value = dq_pkg::PORT_W'(taken_ff);
      end else begin : g_wide
         assign word            = DATA_WIDTH'(req_value);
         assign rsp_taken_value = taken_ff[dq_pkg::PORT_W-1:0];
      end
   endgenerate

   // the chain: cell 0 is the front, its front neighbor is the new word
   assign hit_w[0] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [DATA_WIDTH-1:0] front_nb;
         logic [DATA_WIDTH-1:0] back_nb;

         if (gi == 0) begin : g_first
            assign front_nb = word;
         end else begin : g_mid
            assign front_nb = entry_w[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign back_nb = entry_w[gi];
         end else begin : g_inner
            assign back_nb = entry_w[gi+1];
         end

         dq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (gi)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .word        (word),
            .occ         (occ_ff),
            .front_entry (front_nb),
            .back_entry  (back_nb),
            .hit_in      (hit_w[gi]),
            .hit_out     (hit_w[gi+1]),
            .is_last     (last_w[gi]),
            .entry       (entry_w[gi])
         );
      end
   endgenerate

   // one-hot select of the back entry
   always_comb begin
      back_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         back_word = back_word | (entry_w[i] & {DATA_WIDTH{last_w[i]}});
      end
   end

   assign full  = occ_ff == CNT_W'(CAPACITY);
   assign empty = occ_ff == '0;

   always_comb begin
      cmd       = '0;
      occ_in    = occ_ff;
      taken_in  = '0;
      status_in = dq_pkg::ST_OK;
      unique case (req_action)
         dq_pkg::ACT_PUSH_FRONT: begin
            if (full) begin
               status_in = dq_pkg::ST_FULL;
            end else begin
               cmd.shift_in_front = fire;
               occ_in             = occ_ff + 1'b1;
            end
         end
         dq_pkg::ACT_PUSH_BACK: begin
            if (full) begin
               status_in = dq_pkg::ST_FULL;
            end else begin
               cmd.load_back = fire;
               occ_in        = occ_ff + 1'b1;
            end
         end
         dq_pkg::ACT_TAKE_FRONT: begin
            if (empty) begin
               status_in = dq_pkg::ST_EMPTY;
            end else begin
               cmd.shift_out_front = fire;
               taken_in            = entry_w[0];
               occ_in              = occ_ff - 1'b1;
            end
         end
         dq_pkg::ACT_TAKE_BACK: begin
            if (empty) begin
               status_in = dq_pkg::ST_EMPTY;
            end else begin
               taken_in = back_word;
               occ_in   = occ_ff - 1'b1;
            end
         end
         dq_pkg::ACT_REMOVE: begin
            if (hit_w[CAPACITY]) begin
               cmd.remove = fire;
               taken_in   = word;
               occ_in     = occ_ff - 1'b1;
            end else begin
               status_in = dq_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            occ_ff <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         taken_ff  <= taken_in;
         status_ff <= status_in;
         count_ff  <= occ_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_count    = count_ff;
   assign rsp_is_empty = count_ff == '0;

endmodule
